// ===== sv/scti_pkg.sv =====
// Package for the sine/cosine table interpolator: formats, scale constant and ROM contents.
// The ROM images are built at elaboration by constant functions; no other file is needed.
`default_nettype none
package scti_pkg;

  localparam int TABLE_BITS       = 9;
  localparam int ANGLE_FRAC_BITS  = 16;
  localparam int INTERP_FRAC_BITS = 12;
  localparam int OUT_FRAC_BITS    = 14;

  localparam int ANGLE_W   = 32;
  localparam int VALUE_W   = 16;
  localparam int TABLE_SIZE = 1 << TABLE_BITS;
  localparam int HALF_BITS  = TABLE_BITS - 1;
  localparam int HALF_SIZE  = 1 << HALF_BITS;

  // round(2^32 / (2*pi)), 30 bits
  localparam int INV_W = 30;
  localparam logic [INV_W-1:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam int SCALED_W = ANGLE_W + INV_W;
  // Bits of the scaled angle that matter: table index over interpolation fraction
  localparam int PHASE_W  = TABLE_BITS + INTERP_FRAC_BITS;
  localparam int PHASE_HI = ANGLE_FRAC_BITS + 31;

  // Table entries span [-2^OUT_FRAC_BITS, 2^OUT_FRAC_BITS]
  localparam int ROM_W  = OUT_FRAC_BITS + 2;
  localparam int DIFF_W = ROM_W + 1;
  localparam int PROD_W = DIFF_W + INTERP_FRAC_BITS + 1;
  localparam int RES_W  = (ROM_W + 2 > VALUE_W + 1) ? ROM_W + 2 : VALUE_W + 1;

  localparam logic [TABLE_BITS-1:0] QUARTER_TURN = TABLE_BITS'(TABLE_SIZE / 4);

  typedef logic signed [ROM_W-1:0] rom_word_t;
  typedef rom_word_t rom_half_t [HALF_SIZE];

  localparam longint unsigned ONE_Q30    = 64'd1 << 30;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint unsigned sin_poly(longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    x2 = mul_q30(x, x);
    t = ONE_Q30 - x2 / 72;
    t = ONE_Q30 - mul_q30(x2, t) / 42;
    t = ONE_Q30 - mul_q30(x2, t) / 20;
    t = ONE_Q30 - mul_q30(x2, t) / 6;
    return mul_q30(x, t);
  endfunction

  function automatic longint unsigned cos_poly(longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    x2 = mul_q30(x, x);
    t = ONE_Q30 - x2 / 90;
    t = ONE_Q30 - mul_q30(x2, t) / 56;
    t = ONE_Q30 - mul_q30(x2, t) / 30;
    t = ONE_Q30 - mul_q30(x2, t) / 12;
    return ONE_Q30 - mul_q30(x2, t) / 2;
  endfunction

  // sin(2*pi*i/TABLE_SIZE), octant-reduced Q30 polynomial, rounded half up
  function automatic rom_word_t sine_entry(int unsigned i);
    longint unsigned p;
    longint unsigned r;
    longint unsigned x;
    longint unsigned sv;
    longint unsigned cv;
    longint unsigned v;
    longint unsigned mag;
    longint unsigned quad;
    p = (longint'(i % TABLE_SIZE) << (32 - TABLE_BITS)) & 64'hFFFF_FFFF;
    quad = p >> 30;
    r = p & (ONE_Q30 - 1);
    if (r <= (ONE_Q30 >> 1)) begin
      x  = (r * TWO_PI_Q30) >> 32;
      sv = sin_poly(x);
      cv = cos_poly(x);
    end else begin
      x  = ((ONE_Q30 - r) * TWO_PI_Q30) >> 32;
      sv = cos_poly(x);
      cv = sin_poly(x);
    end
    v = quad[0] ? cv : sv;
    mag = (v + (64'd1 << (29 - OUT_FRAC_BITS))) >> (30 - OUT_FRAC_BITS);
    return quad[1] ? -ROM_W'(mag) : ROM_W'(mag);
  endfunction

  // Even or odd entries of the full-period table
  function automatic rom_half_t gen_half(int unsigned parity);
    rom_half_t t;
    for (int k = 0; k < HALF_SIZE; k++) begin
      t[k] = sine_entry(2 * k + parity);
    end
    return t;
  endfunction

  localparam rom_half_t ROM_EVEN = gen_half(0);
  localparam rom_half_t ROM_ODD  = gen_half(1);

endpackage
`default_nettype wire

// ===== sv/sine_cosine_table_interpolator_unit.sv =====
// An accepted request passes through the stage 1 to stage 4 registers and the value register to the response.
// Throughput: one transaction per cycle; the five stages are elastic, so a stalled
// response holds only the stages behind it and bubbles are filled first.
// Reset (rst, synchronous): clears every stage valid bit; data registers are not reset.
// Top level of the sine/cosine table interpolator; depends on scti_pkg only.
`default_nettype none
module sine_cosine_table_interpolator_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output      logic                          req_stall,
  input  wire logic [scti_pkg::ANGLE_W-1:0]  angle,
  input  wire logic                          action,
  output      logic                          rsp_valid,
  input  wire logic                          rsp_stall,
  output      logic [scti_pkg::VALUE_W-1:0]  value
);
  import scti_pkg::*;

  // Stage 1: magnitude of the angle and the flags
  logic                     s1_valid;
  logic [ANGLE_W-1:0]       s1_mag;
  logic                     s1_cos;
  logic                     s1_neg;
  // Stage 2: scaled phase (index over fraction)
  logic                     s2_valid;
  logic [PHASE_W-1:0]       s2_phase;
  logic                     s2_cos;
  logic                     s2_neg;
  // Stage 3: the two neighbouring table entries
  logic                     s3_valid;
  rom_word_t                s3_base;
  rom_word_t                s3_next;
  logic [INTERP_FRAC_BITS-1:0] s3_frac;
  logic                     s3_flip;
  // Stage 4: interpolation product
  logic                     s4_valid;
  rom_word_t                s4_base;
  logic signed [PROD_W-1:0] s4_prod;
  logic                     s4_flip;

  // Each stage loads when it is empty or its contents move on this cycle
  logic ready1, ready2, ready3, ready4, ready5;
  assign ready5 = !rsp_valid || !rsp_stall;
  assign ready4 = !s4_valid || ready5;
  assign ready3 = !s3_valid || ready4;
  assign ready2 = !s2_valid || ready3;
  assign ready1 = !s1_valid || ready2;
  assign req_stall = !ready1;

  // Stage 1 logic: two's complement magnitude; 0x8000_0000 gives 2^31 unsigned
  logic [ANGLE_W-1:0] mag_next;
  assign mag_next = angle[ANGLE_W-1] ? (ANGLE_W'(0) - angle) : angle;

  // Stage 2 logic: turns = |angle| * 2^32/(2*pi); keep index and fraction bits only
  logic [SCALED_W-1:0] scaled;
  assign scaled = SCALED_W'(s1_mag) * SCALED_W'(INV_TWO_PI_Q32);

  // Stage 3 logic: the entry pair straddles an even and an odd entry, so read
  // one from each half table. Cosine is the sine table a quarter turn on.
  logic [TABLE_BITS-1:0]       entry;
  logic [HALF_BITS-1:0]        half_addr;
  logic [HALF_BITS-1:0]        half_addr_inc;
  rom_word_t                   base_next;
  rom_word_t                   next_next;
  assign entry = s2_phase[PHASE_W-1 -: TABLE_BITS] + (s2_cos ? QUARTER_TURN : '0);
  assign half_addr     = entry[TABLE_BITS-1:1];
  assign half_addr_inc = half_addr + HALF_BITS'(1);

  always_comb begin
    if (entry[0]) begin
      base_next = ROM_ODD[half_addr];
      next_next = ROM_EVEN[half_addr_inc];
    end else begin
      base_next = ROM_EVEN[half_addr];
      next_next = ROM_ODD[half_addr];
    end
  end

  // Stage 4 logic: signed difference times unsigned fraction
  logic signed [DIFF_W-1:0]         diff;
  logic signed [INTERP_FRAC_BITS:0] frac_s;
  logic signed [PROD_W-1:0]         prod_next;
  assign diff      = DIFF_W'(s3_next) - DIFF_W'(s3_base);
  assign frac_s    = $signed({1'b0, s3_frac});
  assign prod_next = PROD_W'(diff) * PROD_W'(frac_s);

  // Stage 5 logic: floor shift, add, negate sine of a negative angle, saturate
  logic signed [RES_W-1:0] step;
  logic signed [RES_W-1:0] sum;
  logic signed [RES_W-1:0] res;
  logic [VALUE_W-1:0]      value_next;
  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(32767);
  localparam logic signed [RES_W-1:0] SAT_LO = -RES_W'(32768);
  assign step = RES_W'(s4_prod >>> INTERP_FRAC_BITS);
  assign sum  = RES_W'(s4_base) + step;
  assign res  = s4_flip ? -sum : sum;

  always_comb begin
    if (res > SAT_HI) begin
      value_next = VALUE_W'(SAT_HI);
    end else if (res < SAT_LO) begin
      value_next = VALUE_W'(SAT_LO);
    end else begin
      value_next = VALUE_W'(res);
    end
  end

  // Valid bits: reset and advance
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (ready1) s1_valid  <= req_valid;
      if (ready2) s2_valid  <= s1_valid;
      if (ready3) s3_valid  <= s2_valid;
      if (ready4) s4_valid  <= s3_valid;
      if (ready5) rsp_valid <= s4_valid;
    end
  end

  // Data registers: load with their stage, hold otherwise
  always_ff @(posedge clk) begin
    if (ready1) begin
      s1_mag <= mag_next;
      s1_cos <= action;
      s1_neg <= angle[ANGLE_W-1];
    end
    if (ready2) begin
      s2_phase <= scaled[PHASE_HI -: PHASE_W];
      s2_cos   <= s1_cos;
      s2_neg   <= s1_neg;
    end
    if (ready3) begin
      s3_base <= base_next;
      s3_next <= next_next;
      s3_frac <= s2_phase[INTERP_FRAC_BITS-1:0];
      s3_flip <= s2_neg && !s2_cos;
    end
    if (ready4) begin
      s4_base <= s3_base;
      s4_prod <= prod_next;
      s4_flip <= s3_flip;
    end
    if (ready5) begin
      value <= value_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/scti_checker.sv =====
// Port-level checker for the sine/cosine table interpolator, bound to the top level.
// Depends on scti_pkg and sine_cosine_table_interpolator_unit.
`default_nettype none
module scti_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_stall,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_stall,
  input wire logic [scti_pkg::VALUE_W-1:0]  value
);
  import scti_pkg::*;

  localparam logic signed [VALUE_W-1:0] V_MAX =
    (OUT_FRAC_BITS >= VALUE_W - 1) ? VALUE_W'(32767) : VALUE_W'(1 << OUT_FRAC_BITS);

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(value))
    else $error("stalled response changed or dropped");

  // Drain the pipeline at reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Deliver an accepted transaction to the response when the output is not stalled in between
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      ##1 !rsp_stall |=> rsp_valid)
    else $error("response missing after pipeline latency");

  // Keep the result within one in magnitude
  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ($signed(value) <= V_MAX) && ($signed(value) >= -V_MAX))
    else $error("result out of range");

endmodule

bind sine_cosine_table_interpolator_unit scti_checker u_scti_checker (.*);
`default_nettype wire

// ===== verif/sine_cosine_table_interpolator_unit_tb.sv =====
// Self-checking testbench for sine_cosine_table_interpolator_unit.
// Holds its own table-and-interpolation predictor; needs scti_pkg and the unit only.
`timescale 1ns / 100ps
module sine_cosine_table_interpolator_unit_tb;

  // Predictor formats, kept apart from the package on purpose
  localparam int TBL_BITS   = 9;
  localparam int TBL_SIZE   = 1 << TBL_BITS;
  localparam int IN_FRAC    = 16;
  localparam int INTERP     = 12;
  localparam int OUT_FRAC   = 14;
  localparam longint unsigned Q30_ONE      = 64'd1 << 30;
  localparam longint unsigned TWO_PI_Q30_C = 64'd6746518852;
  localparam longint unsigned TURN_SCALE   = 64'd683565276;

  localparam logic SEL_SINE   = 1'b0;
  localparam logic SEL_COSINE = 1'b1;

  localparam int QUIET_LIMIT   = 4000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES  = 20;    // well past the five-stage latency
  localparam int ITEMS_PER_PHASE = 275;
  localparam int DIRECTED_ROWS = 22;

  typedef struct {
    logic [31:0] ang;
    logic        sel;
    bit          typed_in;  // want holds a hand-derived value
    logic [15:0] want;
  } trig_row_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          req_valid = 1'b0;
  logic                          req_stall;
  logic [scti_pkg::ANGLE_W-1:0]  angle = '0;
  logic                          action = SEL_SINE;
  logic                          rsp_valid;
  logic                          rsp_stall = 1'b0;
  logic [scti_pkg::VALUE_W-1:0]  value;

  int          sine_q14 [TBL_SIZE];
  trig_row_t   directed_rows [DIRECTED_ROWS];
  logic [15:0] trig_value_q [$];
  logic [15:0] want_value;

  int sender_idle_pct = 0;
  int rsp_stall_pct   = 0;
  int idle_pct_by_phase  [4] = '{0, 80, 0, 33};
  int stall_pct_by_phase [4] = '{0, 0, 80, 33};

  int sent_count    = 0;
  int sine_count    = 0;
  int cosine_count  = 0;
  int neg_count     = 0;
  int checked_count = 0;
  int fail_count    = 0;
  int quiet_cycles  = 0;

  sine_cosine_table_interpolator_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .angle     (angle),
    .action    (action),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .value     (value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: Q30 Horner polynomials build the table, then interpolate.
  // ---------------------------------------------------------------------------
  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint unsigned taylor_sin(longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    x2 = q30_mul(x, x);
    t = Q30_ONE - x2 / 72;
    t = Q30_ONE - q30_mul(x2, t) / 42;
    t = Q30_ONE - q30_mul(x2, t) / 20;
    t = Q30_ONE - q30_mul(x2, t) / 6;
    return q30_mul(x, t);
  endfunction

  function automatic longint unsigned taylor_cos(longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    x2 = q30_mul(x, x);
    t = Q30_ONE - x2 / 90;
    t = Q30_ONE - q30_mul(x2, t) / 56;
    t = Q30_ONE - q30_mul(x2, t) / 30;
    t = Q30_ONE - q30_mul(x2, t) / 12;
    return Q30_ONE - q30_mul(x2, t) / 2;
  endfunction

  // One table word: sin(2*pi*i/TBL_SIZE) rounded half up to Q1.14
  function automatic int sine_word(int i);
    longint unsigned ph;
    longint unsigned rem;
    longint unsigned x;
    longint unsigned s;
    longint unsigned c;
    longint unsigned v;
    longint unsigned m;
    int              quad;
    ph   = (64'(i & (TBL_SIZE - 1)) << (32 - TBL_BITS)) & 64'hFFFF_FFFF;
    quad = int'(ph >> 30);
    rem  = ph & (Q30_ONE - 1);
    // Fold into the first octant; past it, swap the roles of sine and cosine
    if (rem <= (Q30_ONE >> 1)) begin
      x = (rem * TWO_PI_Q30_C) >> 32;
      s = taylor_sin(x);
      c = taylor_cos(x);
    end else begin
      x = ((Q30_ONE - rem) * TWO_PI_Q30_C) >> 32;
      s = taylor_cos(x);
      c = taylor_sin(x);
    end
    v = quad[0] ? c : s;
    m = (v + (64'd1 << (29 - OUT_FRAC))) >> (30 - OUT_FRAC);
    return quad[1] ? -int'(m) : int'(m);
  endfunction

  function automatic logic [15:0] interpolate_trig(logic [31:0] a, logic sel);
    logic            neg;
    longint unsigned mag;
    longint unsigned scaled;
    int              idx;
    int              frac;
    int              off;
    int              lo;
    int              hi;
    longint          prod;
    longint          res;
    neg    = a[31];
    // Most negative angle gives magnitude 2^31 exactly
    mag    = neg ? (64'h1_0000_0000 - 64'(a)) : 64'(a);
    scaled = mag * TURN_SCALE;
    idx    = int'((scaled >> (IN_FRAC + 32 - TBL_BITS)) & (TBL_SIZE - 1));
    frac   = int'((scaled >> (IN_FRAC + 32 - TBL_BITS - INTERP)) & ((1 << INTERP) - 1));
    off    = (sel == SEL_COSINE) ? TBL_SIZE / 4 : 0;
    lo     = sine_q14[(idx + off) & (TBL_SIZE - 1)];
    hi     = sine_q14[(idx + 1 + off) & (TBL_SIZE - 1)];
    prod   = longint'(hi - lo) * longint'(frac);
    // Arithmetic shift: the step floors, also when the slope is negative
    res    = longint'(lo) + (prod >>> INTERP);
    if (neg && sel == SEL_SINE) begin
      res = -res;
    end
    if (res > 32767) begin
      res = 32767;
    end
    if (res < -32768) begin
      res = -32768;
    end
    return 16'(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Mix of full-range words, a few turns either side of zero, points near table
  // steps, and the neighbourhood of both ends of the range.
  function automatic logic [31:0] random_angle();
    real         step_q16;
    int          k;
    logic [31:0] a;
    step_q16 = 2.0 * 3.14159265358979 * 65536.0 / TBL_SIZE;
    case ($urandom_range(3))
      0: begin
        a = $urandom;
      end
      1: begin
        a = $urandom_range(4 * 411775);
        if ($urandom_range(1)) a = -a;
      end
      2: begin
        k = $urandom_range(4 * TBL_SIZE);
        a = int'(k * step_q16) + $urandom_range(6) - 3;
        if ($urandom_range(1)) a = -a;
      end
      default: begin
        a = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(255)
                              : 32'h8000_0000 + $urandom_range(255);
      end
    endcase
    return a;
  endfunction

  // Offer one request transaction; hold it until accepted, then queue its result.
  task automatic send_req(input logic [31:0] a, input logic sel, input bit typed_in,
                          input logic [15:0] want);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    angle     <= a;
    action    <= sel;
    do @(posedge clk); while (req_stall);
    trig_value_q.push_back(typed_in ? want : interpolate_trig(a, sel));
    sent_count++;
    if (sel == SEL_COSINE) cosine_count++;
    else sine_count++;
    if (a[31]) neg_count++;
  endtask

  // Receiver back-pressure, redrawn every cycle at the falling edge
  always @(negedge clk) begin
    rsp_stall <= rst ? 1'b0 : ($urandom_range(99) < rsp_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (trig_value_q.size() == 0) begin
        $error("unexpected response transaction, value %0d", $signed(value));
        fail_count++;
      end else begin
        want_value = trig_value_q.pop_front();
        if (value !== want_value) begin
          $error("value mismatch: expected %0d, actual %0d",
                 $signed(want_value), $signed(value));
          fail_count++;
        end
        checked_count++;
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves on either side
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < TBL_SIZE; i++) begin
      sine_q14[i] = sine_word(i);
    end

    // Hand values: zero angle, and sine one LSB either side; the rest go to the predictor
    directed_rows = '{
      '{32'd0,           SEL_SINE,   1'b1, 16'd0},
      '{32'd0,           SEL_COSINE, 1'b1, 16'd16384},
      '{32'd1,           SEL_SINE,   1'b1, 16'd0},
      '{32'hFFFF_FFFF,   SEL_SINE,   1'b1, 16'd0},
      '{32'd1,           SEL_COSINE, 1'b0, 16'd0},
      '{32'hFFFF_FFFF,   SEL_COSINE, 1'b0, 16'd0},
      '{32'h7FFF_FFFF,   SEL_SINE,   1'b0, 16'd0},
      '{32'h7FFF_FFFF,   SEL_COSINE, 1'b0, 16'd0},
      '{32'h8000_0000,   SEL_SINE,   1'b0, 16'd0},
      '{32'h8000_0000,   SEL_COSINE, 1'b0, 16'd0},
      '{32'd102944,      SEL_SINE,   1'b0, 16'd0},
      '{32'd102944,      SEL_COSINE, 1'b0, 16'd0},
      '{-32'sd102944,    SEL_SINE,   1'b0, 16'd0},
      '{-32'sd102944,    SEL_COSINE, 1'b0, 16'd0},
      '{32'd205887,      SEL_SINE,   1'b0, 16'd0},
      '{-32'sd205887,    SEL_COSINE, 1'b0, 16'd0},
      '{32'd411775,      SEL_SINE,   1'b0, 16'd0},
      '{32'd411775,      SEL_COSINE, 1'b0, 16'd0},
      // Last table step: the following entry wraps to the start
      '{32'd410971,      SEL_SINE,   1'b0, 16'd0},
      '{32'd410971,      SEL_COSINE, 1'b0, 16'd0},
      '{-32'sd410971,    SEL_SINE,   1'b0, 16'd0},
      '{32'd1000000,     SEL_COSINE, 1'b0, 16'd0}
    };

    // Hold reset, then release it at a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_req(directed_rows[r].ang, directed_rows[r].sel,
               directed_rows[r].typed_in, directed_rows[r].want);
    end

    // Random part, one idling profile per phase
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_pct_by_phase[ph];
      rsp_stall_pct   = stall_pct_by_phase[ph];
      repeat (ITEMS_PER_PHASE) begin
        send_req(random_angle(), logic'($urandom_range(1)), 1'b0, 16'd0);
      end
    end
    @(negedge clk);
    req_valid <= 1'b0;

    // Drain: wait for every queued result, then let the pipeline settle
    while (trig_value_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d angles (%0d sine, %0d cosine, %0d negative), %0d results checked,",
             sent_count, sine_count, cosine_count, neg_count, checked_count);
    $display("with sender gaps and receiver back-pressure in four profiles; %0d failures.",
             fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/scti_pkg.sv
sv/sine_cosine_table_interpolator_unit.sv
sv/scti_checker.sv
verif/sine_cosine_table_interpolator_unit_tb.sv
